/* hw/rtl/protection_region_cover_core_assert.svh */
// assertion macros for the protection region cover block
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef PROTECTION_REGION_COVER_CORE_ASSERT_SVH
`define PROTECTION_REGION_COVER_CORE_ASSERT_SVH

`ifndef SYNTH
// clocked assertion, switched off while reset is asserted
`define PRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked assertion that also holds during reset
`define PRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/prcov_pkg.sv */
// shared types and constants for the protection region cover block
// no dependencies
`timescale 1ns / 1ps

package prcov_pkg;

    localparam int ADDR_W          = 32;
    localparam int COVER_CODE_W    = 5;
    localparam int SUB_COUNT       = 8;
    localparam int SUB_IDX_W       = 3;
    localparam int MIN_REGION_DEF  = 256;

    // one request: target byte range
    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [ADDR_W-1:0] span_length;
    } t_prcov_req;

    // one result: covering region description
    typedef struct packed {
        logic                    ok;
        logic [ADDR_W-1:0]       cover_base;
        logic [COVER_CODE_W-1:0] cover_code;
        logic [SUB_COUNT-1:0]    sub_off;
        logic                    exact_fit;
    } t_prcov_rsp;

endpackage

/* hw/rtl/prcov_calc.sv */
// combinational region search: leading-one detect, masking, subregion map
// depends on prcov_pkg
`timescale 1ns / 1ps

module prcov_calc
    import prcov_pkg::*;
#(
    parameter int MIN_REGION_SIZE = MIN_REGION_DEF
) (
    input  t_prcov_req i_req,
    output t_prcov_rsp o_rsp
);

    localparam int MinLog = $clog2(MIN_REGION_SIZE);
    localparam int KW     = $clog2(ADDR_W + 1);

    // highest set bit position plus one, zero for an all-zero word
    function automatic logic [KW-1:0] lead_pos(input logic [ADDR_W-1:0] d);
        logic [KW-1:0] pos;
        pos = '0;
        for (int i = 0; i < ADDR_W; i++) begin
            if (d[i]) begin
                pos = KW'(i + 1);
            end
        end
        return pos;
    endfunction

    logic [ADDR_W:0]        end_sum;
    logic [ADDR_W:0]        last_sum;
    logic [ADDR_W-1:0]      last_addr;
    logic                   range_ok;
    logic [KW-1:0]          diff_pos;
    logic [KW-1:0]          size_log;
    logic [KW-1:0]          sub_log;
    logic [ADDR_W-1:0]      low_mask;
    logic [ADDR_W-1:0]      sub_mask;
    logic [SUB_IDX_W-1:0]   lo_idx;
    logic [SUB_IDX_W-1:0]   hi_idx;
    logic [SUB_COUNT-1:0]   dis_mask;
    logic                   exact;

    assign end_sum   = {1'b0, i_req.base_address} + {1'b0, i_req.span_length};
    assign last_sum  = {1'b0, i_req.base_address} + {1'b0, i_req.span_length}
                     - {{ADDR_W{1'b0}}, 1'b1};
    assign last_addr = last_sum[ADDR_W-1:0];

    // reject empty spans and spans ending past the top of the address space
    assign range_ok = (i_req.span_length != '0)
                    && !(end_sum[ADDR_W] && (end_sum[ADDR_W-1:0] != '0));

    assign diff_pos = lead_pos(i_req.base_address ^ last_addr);
    assign size_log = (diff_pos > KW'(MinLog)) ? diff_pos : KW'(MinLog);
    assign sub_log  = size_log - KW'(SUB_IDX_W);

    assign low_mask = ~({ADDR_W{1'b1}} << size_log);
    assign sub_mask = ~({ADDR_W{1'b1}} << sub_log);

    assign lo_idx = SUB_IDX_W'(i_req.base_address >> sub_log);
    assign hi_idx = SUB_IDX_W'(last_addr >> sub_log);

    always_comb begin
        for (int i = 0; i < SUB_COUNT; i++) begin
            dis_mask[i] = !((SUB_IDX_W'(i) >= lo_idx) && (SUB_IDX_W'(i) <= hi_idx));
        end
    end

    assign exact = ((i_req.base_address & sub_mask) == '0)
                && ((end_sum[ADDR_W-1:0] & sub_mask) == '0);

    always_comb begin
        o_rsp = '0;
        if (range_ok) begin
            o_rsp.ok         = 1'b1;
            o_rsp.cover_base = i_req.base_address & ~low_mask;
            o_rsp.cover_code = COVER_CODE_W'(size_log - KW'(1));
            o_rsp.sub_off    = dis_mask;
            o_rsp.exact_fit  = exact;
        end
    end

endmodule

/* hw/rtl/protection_region_cover_core.sv */
// top level of the protection region cover block: request and result registers
// depends on prcov_pkg, prcov_calc and protection_region_cover_core_assert.svh
`timescale 1ns / 1ps
`include "protection_region_cover_core_assert.svh"

// channel   direction  valid     stall     payload
// request   in         i_valid   o_stall   i_req  (t_prcov_req)
// result    out        o_valid   i_stall   o_rsp  (t_prcov_rsp)
//
// a request can be taken every cycle while o_stall is low; it is held in the request
// register, from which its result is loaded into the result register and leaves the block
// the work sits between the request register and the result register
// reset is synchronous and active low and clears only the two valid flags
// a stalled result holds in its register while one more request is still taken
// o_stall rises only when both registers are full and the result is stalled

module protection_region_cover_core
    import prcov_pkg::*;
#(
    parameter int MIN_REGION_SIZE = MIN_REGION_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_prcov_req i_req,
    output logic       o_valid,
    input  logic       i_stall,
    output t_prcov_rsp o_rsp
);

    // request stage
    logic       r_in_valid;
    logic       n_in_valid;
    t_prcov_req r_in_req;

    // result stage
    logic       r_out_valid;
    logic       n_out_valid;
    t_prcov_rsp r_out_rsp;

    t_prcov_rsp calc_rsp;

    logic out_free;
    logic in_free;
    logic in_take;
    logic out_load;

    // result register can load when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_stall;
    // request register can load when empty or moving on
    assign in_free  = !r_in_valid || out_free;
    assign in_take  = i_valid && in_free;
    assign out_load = r_in_valid && out_free;

    assign n_in_valid  = in_take || (r_in_valid && !out_free);
    assign n_out_valid = out_load || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req <= i_req;
        end
        if (out_load) begin
            r_out_rsp <= calc_rsp;
        end
    end

    // region search between the two registers
    prcov_calc #(
        .MIN_REGION_SIZE (MIN_REGION_SIZE)
    ) u_calc (
        .i_req (r_in_req),
        .o_rsp (calc_rsp)
    );

    assign o_stall = !in_free;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_rsp;

    // rejected results carry no other information
    `PRC_ASSERT(a_reject_zero, i_clk, i_rst_n,
        (r_out_valid && !r_out_rsp.ok) |-> ((r_out_rsp.cover_base == '0)
        && (r_out_rsp.cover_code == '0) && (r_out_rsp.sub_off == '0)
        && !r_out_rsp.exact_fit), "rejected result has nonzero fields")
    // a found region is never below the minimum size
    `PRC_ASSERT(a_min_size, i_clk, i_rst_n,
        (r_out_valid && r_out_rsp.ok) |-> (r_out_rsp.cover_code
        >= COVER_CODE_W'($clog2(MIN_REGION_SIZE) - 1)), "region below minimum size")
    // at least one subregion touches the target
    `PRC_ASSERT(a_some_sub, i_clk, i_rst_n,
        (r_out_valid && r_out_rsp.ok) |-> (r_out_rsp.sub_off != {SUB_COUNT{1'b1}}),
        "all subregions disabled")
    // a pending request moves to the result stage when it is free
    `PRC_ASSERT(a_advance, i_clk, i_rst_n,
        (r_in_valid && !(r_out_valid && i_stall)) |=> r_out_valid,
        "request lost between stages")
    // an empty request stage never stalls upstream
    `PRC_ASSERT_ALWAYS(a_no_idle_stall, i_clk, !r_in_valid |-> !o_stall, "stall with empty request stage")

endmodule
